// ----- rtl/kcm_pkg.sv -----
// Shared types, constants and the sine table function of the keyed carrier modulator.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package kcm_pkg;

    localparam int KCM_PHASE_BITS      = 32;
    localparam int KCM_TABLE_ADDR_BITS = 10;
    localparam int KCM_SAMPLE_BITS     = 16;

    localparam int STEP_BITS      = 32;
    localparam int AMP_BITS       = 15;
    localparam int MODE_BITS      = 2;
    localparam int APB_DATA_BITS  = 32;
    localparam int APB_ADDR_BITS  = 5;
    localparam int REG_INDEX_BITS = 3;

    localparam int FIFO_DEPTH     = 8;
    localparam int FIFO_PTR_BITS  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS  = $clog2(FIFO_DEPTH + 1);

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;

    localparam logic [STEP_BITS-1:0] STEP_A_RESET   = 32'd85899346;
    localparam logic [STEP_BITS-1:0] STEP_B_RESET   = 32'd94489281;
    localparam logic [AMP_BITS-1:0]  AMP_ZERO_RESET = 15'd0;
    localparam logic [AMP_BITS-1:0]  AMP_ONE_RESET  = 15'd32767;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_ASK = 2'd0,
        MODE_FSK = 2'd1,
        MODE_PSK = 2'd2
    } kcm_mode_t;

    typedef enum logic [REG_INDEX_BITS-1:0] {
        REG_MODE     = 3'd0,
        REG_STEP_A   = 3'd1,
        REG_STEP_B   = 3'd2,
        REG_AMP_ZERO = 3'd3,
        REG_AMP_ONE  = 3'd4
    } kcm_reg_index_t;

    // Quarter-wave sine entry: degree-15 Taylor polynomial in Horner form, Q30 terms,
    // rounded to the sample full scale and clamped. Evaluated at elaboration only.
    function automatic logic [63:0] sine_entry(input int unsigned idx,
                                               input int unsigned tab_bits,
                                               input int unsigned sbits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] s;
        logic [63:0] v;
        logic [63:0] full;
        x    = (64'(idx) * HALF_PI_Q30) >> tab_bits;
        x2   = (x * x) >> 30;
        term = Q30_ONE;
        term = Q30_ONE - ((x2 * term) >> 30) / 64'd210;
        term = Q30_ONE - ((x2 * term) >> 30) / 64'd156;
        term = Q30_ONE - ((x2 * term) >> 30) / 64'd110;
        term = Q30_ONE - ((x2 * term) >> 30) / 64'd72;
        term = Q30_ONE - ((x2 * term) >> 30) / 64'd42;
        term = Q30_ONE - ((x2 * term) >> 30) / 64'd20;
        term = Q30_ONE - ((x2 * term) >> 30) / 64'd6;
        s    = (x * term) >> 30;
        full = (64'd1 << (sbits - 1)) - 64'd1;
        v    = (s * full + (64'd1 << 29)) >> 30;
        if (v > full)
        begin
            v = full;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/keyed_carrier_modulator_unit.sv -----
// Top level of the ASK/FSK/PSK keyed carrier modulator with two phase accumulators.
// Depends on kcm_pkg and instantiates kcm_sine_rom.
//
//   channel   direction  handshake             payload
//   in        input      in_valid / in_stall   data_bit
//   out       output     out_valid / out_stall sample
//   config    input      APB psel/penable      paddr, pwdata, prdata, pready
//
// One data word is taken per clock while in_stall is low.
// The only loop is the phase accumulator add; table read, amplitude multiply and rounding
// are separate pipeline stages. Results queue in an eight-word output buffer; input stall
// rises only when eight words are in flight. Reset clears the accumulators, the registers
// and the pipeline; the sine table is constant and needs no clearing.
`default_nettype none

module keyed_carrier_modulator_unit
    import kcm_pkg::*;
#(
    parameter int PHASE_BITS      = KCM_PHASE_BITS,
    parameter int TABLE_ADDR_BITS = KCM_TABLE_ADDR_BITS,
    parameter int SAMPLE_BITS     = KCM_SAMPLE_BITS
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            data_bit,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [SAMPLE_BITS-1:0]   sample,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [APB_ADDR_BITS-1:0]        paddr,
    input  logic [APB_DATA_BITS-1:0]        pwdata,
    output logic [APB_DATA_BITS-1:0]        prdata,
    output logic                            pready
);

    localparam int QUAD_BITS = TABLE_ADDR_BITS + 2;
    localparam int ROM_ADDR_BITS = TABLE_ADDR_BITS + 1;
    localparam int MAG_BITS = SAMPLE_BITS - 1;
    localparam int PROD_BITS = MAG_BITS + AMP_BITS;
    localparam logic [ROM_ADDR_BITS-1:0] QUARTER_LEN = {1'b1, {TABLE_ADDR_BITS{1'b0}}};
    localparam logic [PROD_BITS-1:0] ROUND_HALF = PROD_BITS'(1) << (AMP_BITS - 1);

    logic [MODE_BITS-1:0] mode_reg;
    logic [STEP_BITS-1:0] step_a_reg;
    logic [STEP_BITS-1:0] step_b_reg;
    logic [AMP_BITS-1:0]  amp_zero_reg;
    logic [AMP_BITS-1:0]  amp_one_reg;

    logic                      cfg_write;
    logic [REG_INDEX_BITS-1:0] reg_index;

    logic                  in_accept;
    logic                  out_accept;
    logic [PHASE_BITS-1:0] phase_a_reg;
    logic [PHASE_BITS-1:0] phase_b_reg;
    logic [PHASE_BITS-1:0] phase_a_next;
    logic [PHASE_BITS-1:0] phase_b_next;

    logic                 s1_valid_reg;
    logic                 s1_bit_reg;
    logic [QUAD_BITS-1:0] s1_ang_a_reg;
    logic [QUAD_BITS-1:0] s1_ang_b_reg;

    logic                       sel_b;
    logic [QUAD_BITS-1:0]       ang;
    logic [1:0]                 quad;
    logic [ROM_ADDR_BITS-1:0]   idx_ext;
    logic [ROM_ADDR_BITS-1:0]   rom_addr;
    logic                       s1_neg;
    logic                       s1_zero;
    logic                       s1_use_amp;

    logic                s2_valid_reg;
    logic                s2_neg_reg;
    logic                s2_zero_reg;
    logic                s2_use_amp_reg;
    logic [AMP_BITS-1:0] s2_amp_reg;
    logic [MAG_BITS-1:0] rom_data;
    logic [PROD_BITS-1:0] prod;

    logic                 s3_valid_reg;
    logic                 s3_neg_reg;
    logic                 s3_zero_reg;
    logic [PROD_BITS-1:0] s3_prod_reg;
    logic [PROD_BITS-1:0] rounded;
    logic [MAG_BITS-1:0]  mag;
    logic signed [SAMPLE_BITS-1:0] result;

    logic signed [SAMPLE_BITS-1:0] fifo_mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] wr_ptr_reg;
    logic [FIFO_PTR_BITS-1:0] rd_ptr_reg;
    logic [FIFO_CNT_BITS-1:0] level_reg;
    logic [FIFO_CNT_BITS-1:0] level_next;
    logic [FIFO_CNT_BITS-1:0] credit_reg;
    logic [FIFO_CNT_BITS-1:0] credit_next;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;
    assign reg_index = paddr[APB_ADDR_BITS-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_ASK;
            step_a_reg   <= STEP_A_RESET;
            step_b_reg   <= STEP_B_RESET;
            amp_zero_reg <= AMP_ZERO_RESET;
            amp_one_reg  <= AMP_ONE_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                REG_MODE:     mode_reg     <= pwdata[MODE_BITS-1:0];
                REG_STEP_A:   step_a_reg   <= pwdata[STEP_BITS-1:0];
                REG_STEP_B:   step_b_reg   <= pwdata[STEP_BITS-1:0];
                REG_AMP_ZERO: amp_zero_reg <= pwdata[AMP_BITS-1:0];
                REG_AMP_ONE:  amp_one_reg  <= pwdata[AMP_BITS-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_MODE:     prdata = APB_DATA_BITS'(mode_reg);
            REG_STEP_A:   prdata = APB_DATA_BITS'(step_a_reg);
            REG_STEP_B:   prdata = APB_DATA_BITS'(step_b_reg);
            REG_AMP_ZERO: prdata = APB_DATA_BITS'(amp_zero_reg);
            REG_AMP_ONE:  prdata = APB_DATA_BITS'(amp_one_reg);
            default:      prdata = '0;
        endcase
    end

    // Phase accumulators; each word uses the phase before its own advance.
    assign in_stall   = (credit_reg == FIFO_CNT_BITS'(FIFO_DEPTH));
    assign in_accept  = in_valid & ~in_stall;
    assign out_valid  = (level_reg != '0);
    assign out_accept = out_valid & ~out_stall;

    assign phase_a_next = phase_a_reg + PHASE_BITS'(step_a_reg);
    assign phase_b_next = phase_b_reg + PHASE_BITS'(step_b_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_a_reg  <= '0;
            phase_b_reg  <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_accept;
            if (in_accept)
            begin
                phase_a_reg <= phase_a_next;
                phase_b_reg <= phase_b_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_bit_reg   <= data_bit;
            s1_ang_a_reg <= phase_a_reg[PHASE_BITS-1 -: QUAD_BITS];
            s1_ang_b_reg <= phase_b_reg[PHASE_BITS-1 -: QUAD_BITS];
        end
    end

    // Stage one: pick the carrier, fold the angle into the first quadrant, set the sign.
    assign sel_b    = (mode_reg == MODE_FSK) && s1_bit_reg;
    assign ang      = sel_b ? s1_ang_b_reg : s1_ang_a_reg;
    assign quad     = ang[QUAD_BITS-1 -: 2];
    assign idx_ext  = {1'b0, ang[TABLE_ADDR_BITS-1:0]};
    assign rom_addr = quad[0] ? (QUARTER_LEN - idx_ext) : idx_ext;

    always_comb
    begin
        s1_use_amp = 1'b0;
        s1_zero    = 1'b0;
        case (mode_reg)
            MODE_ASK:
            begin
                s1_neg     = ~quad[1];
                s1_use_amp = 1'b1;
            end
            MODE_FSK: s1_neg = ~quad[1];
            MODE_PSK: s1_neg = quad[1] ^ s1_bit_reg;
            default:
            begin
                s1_neg  = 1'b0;
                s1_zero = 1'b1;
            end
        endcase
    end

    kcm_sine_rom #(
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
        .SAMPLE_BITS     (SAMPLE_BITS)
    ) u_kcm_sine_rom (
        .clk  (clk),
        .addr (rom_addr),
        .data (rom_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_neg_reg     <= s1_neg;
        s2_zero_reg    <= s1_zero;
        s2_use_amp_reg <= s1_use_amp;
        s2_amp_reg     <= s1_bit_reg ? amp_one_reg : amp_zero_reg;
        s3_neg_reg     <= s2_neg_reg;
        s3_zero_reg    <= s2_zero_reg;
        s3_prod_reg    <= prod;
    end

    // Stage two: amplitude product; without amplitude keying the magnitude is
    // placed so that the rounding shift returns it unchanged.
    assign prod = s2_use_amp_reg ? (PROD_BITS'(rom_data) * PROD_BITS'(s2_amp_reg))
                                 : {rom_data, {AMP_BITS{1'b0}}};

    // Stage three: round, apply the sign, or give zero for the unused mode.
    assign rounded = (s3_prod_reg + ROUND_HALF) >> AMP_BITS;
    assign mag     = rounded[MAG_BITS-1:0];

    always_comb
    begin
        if (s3_zero_reg)
        begin
            result = '0;
        end
        else if (s3_neg_reg)
        begin
            result = -$signed({1'b0, mag});
        end
        else
        begin
            result = $signed({1'b0, mag});
        end
    end

    // Output buffer and in-flight word count.
    always_comb
    begin
        level_next  = level_reg;
        credit_next = credit_reg;
        if (s3_valid_reg && !out_accept)
        begin
            level_next = level_reg + FIFO_CNT_BITS'(1);
        end
        else if (!s3_valid_reg && out_accept)
        begin
            level_next = level_reg - FIFO_CNT_BITS'(1);
        end
        if (in_accept && !out_accept)
        begin
            credit_next = credit_reg + FIFO_CNT_BITS'(1);
        end
        else if (!in_accept && out_accept)
        begin
            credit_next = credit_reg - FIFO_CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
            credit_reg <= '0;
        end
        else
        begin
            level_reg  <= level_next;
            credit_reg <= credit_next;
            if (s3_valid_reg)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_BITS'(1);
            end
            if (out_accept)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_valid_reg)
        begin
            fifo_mem_reg[wr_ptr_reg] <= result;
        end
    end

    assign sample = fifo_mem_reg[rd_ptr_reg];

endmodule

`default_nettype wire

// ----- rtl/kcm_sine_rom.sv -----
// Quarter-wave sine ROM with a registered read port.
// Depends on kcm_pkg for the table function that fills it at elaboration.
`default_nettype none

module kcm_sine_rom
    import kcm_pkg::*;
#(
    parameter int TABLE_ADDR_BITS = KCM_TABLE_ADDR_BITS,
    parameter int SAMPLE_BITS     = KCM_SAMPLE_BITS
)
(
    input  logic                       clk,
    input  logic [TABLE_ADDR_BITS:0]   addr,
    output logic [SAMPLE_BITS-2:0]     data
);

    localparam int DEPTH  = (1 << TABLE_ADDR_BITS) + 1;
    localparam int DATA_W = SAMPLE_BITS - 1;

    logic [DATA_W-1:0] rom_table [DEPTH];
    logic [DATA_W-1:0] data_reg;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_entry
        assign rom_table[i] = DATA_W'(sine_entry(i, TABLE_ADDR_BITS, SAMPLE_BITS));
    end

    always_ff @(posedge clk)
    begin
        data_reg <= rom_table[addr];
    end

    assign data = data_reg;

endmodule

`default_nettype wire

// ----- rtl/kcm_checker.sv -----
// Port-level checker for the keyed carrier modulator, bound to its top level.
// Depends on kcm_pkg for the buffer depth.
`default_nettype none

module kcm_checker
    import kcm_pkg::*;
#(
    parameter int SAMPLE_BITS = KCM_SAMPLE_BITS
)
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic signed [SAMPLE_BITS-1:0] sample
);

    localparam logic signed [SAMPLE_BITS-1:0] MOST_NEGATIVE = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic [FIFO_CNT_BITS:0] pending_reg;
    logic                   in_take;
    logic                   out_take;

    assign in_take  = in_valid & ~in_stall;
    assign out_take = out_valid & ~out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (in_take && !out_take)
        begin
            pending_reg <= pending_reg + (FIFO_CNT_BITS+1)'(1);
        end
        else if (!in_take && out_take)
        begin
            pending_reg <= pending_reg - (FIFO_CNT_BITS+1)'(1);
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sample))
        else $error("stalled output word changed");

    a_no_spurious_word: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == '0 |-> !out_valid)
        else $error("output word without a pending input word");

    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == '0 |-> !in_stall)
        else $error("input stalled with nothing in flight");

    a_sample_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> sample != MOST_NEGATIVE)
        else $error("sample beyond full scale");

endmodule

bind keyed_carrier_modulator_unit kcm_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_kcm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sample    (sample)
);

`default_nettype wire

// ----- bench/tb_top.sv -----
// Self-checking testbench of keyed_carrier_modulator_unit: ASK, FSK and PSK samples against
// a local bit-exact modulator model, with APB register phases and random stalls on both sides.
// Depends on kcm_pkg and the RTL of the block.
`default_nettype none

module tb_top;
    import kcm_pkg::*;

    localparam int PH_BITS     = KCM_PHASE_BITS;
    localparam int TAB_BITS    = KCM_TABLE_ADDR_BITS;
    localparam int SMP_BITS    = KCM_SAMPLE_BITS;
    localparam int QUARTER     = 1 << TAB_BITS;
    localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
    localparam longint unsigned ONE_Q30     = 64'd1 << 30;
    localparam longint unsigned FULL        = (64'd1 << (SMP_BITS - 1)) - 64'd1;

    localparam logic [MODE_BITS-1:0] MODE_NONE = 2'd3;
    localparam int SPARE_REG_FIRST = 5;
    localparam int HOLD_CYCLES     = 60;
    localparam int TAIL_CYCLES     = 16;
    localparam int CYCLE_LIMIT     = 300000;
    localparam int RANDOM_PHASES   = 8;
    localparam int PHASE_WORDS     = 55;

    class carrier_scoreboard;
        logic [MODE_BITS-1:0]         mode;
        logic [STEP_BITS-1:0]         step_a;
        logic [STEP_BITS-1:0]         step_b;
        logic [AMP_BITS-1:0]          amp_zero;
        logic [AMP_BITS-1:0]          amp_one;
        logic [PH_BITS-1:0]           acc_a;
        logic [PH_BITS-1:0]           acc_b;
        int                           quarter_wave[0:QUARTER];
        logic signed [SMP_BITS-1:0]   expected_samples[$];
        int                           err_count;

        function new();
            for (int i = 0; i <= QUARTER; i++)
            begin
                quarter_wave[i] = sine_value(i);
            end
            mode      = MODE_ASK;
            step_a    = 32'd85899346;
            step_b    = 32'd94489281;
            amp_zero  = 15'd0;
            amp_one   = 15'd32767;
            acc_a     = '0;
            acc_b     = '0;
            err_count = 0;
        endfunction

        function int sine_value(input int unsigned i);
            longint unsigned ang;
            longint unsigned ang2;
            longint unsigned poly;
            longint unsigned mag;
            ang  = (longint'(i) * PI_HALF_Q30) >> TAB_BITS;
            ang2 = (ang * ang) >> 30;
            poly = ONE_Q30;
            for (int k = 7; k >= 1; k--)
            begin
                poly = ONE_Q30 - ((ang2 * poly) >> 30) / longint'(2 * k * (2 * k + 1));
            end
            mag = (((ang * poly) >> 30) * FULL + (64'd1 << 29)) >> 30;
            if (mag > FULL)
            begin
                mag = FULL;
            end
            return int'(mag);
        endfunction

        function int carrier_at(input logic [PH_BITS-1:0] ph);
            logic [TAB_BITS+1:0] top;
            int                  v;
            top = ph[PH_BITS-1 -: TAB_BITS + 2];
            if (top[TAB_BITS])
            begin
                v = quarter_wave[QUARTER - int'(top[TAB_BITS-1:0])];
            end
            else
            begin
                v = quarter_wave[int'(top[TAB_BITS-1:0])];
            end
            return top[TAB_BITS+1] ? -v : v;
        endfunction

        function void write_reg(input logic [REG_INDEX_BITS-1:0] idx,
                                input logic [APB_DATA_BITS-1:0] v);
            case (idx)
                REG_MODE:     mode     = v[MODE_BITS-1:0];
                REG_STEP_A:   step_a   = v[STEP_BITS-1:0];
                REG_STEP_B:   step_b   = v[STEP_BITS-1:0];
                REG_AMP_ZERO: amp_zero = v[AMP_BITS-1:0];
                REG_AMP_ONE:  amp_one  = v[AMP_BITS-1:0];
                default:      ;
            endcase
        endfunction

        function void note_word(input bit b);
            int     sa;
            int     y;
            longint m;
            longint p;
            sa = carrier_at(acc_a);
            case (mode)
                MODE_ASK:
                begin
                    m = (sa < 0) ? -sa : sa;
                    p = (m * longint'(b ? amp_one : amp_zero) + 16384) >> 15;
                    y = (sa < 0) ? int'(p) : -int'(p);
                end
                MODE_FSK: y = b ? -carrier_at(acc_b) : -sa;
                MODE_PSK: y = b ? -sa : sa;
                default:  y = 0;
            endcase
            expected_samples.insert(expected_samples.size(), SMP_BITS'(y));
            acc_a = acc_a + step_a;
            acc_b = acc_b + step_b;
        endfunction

        function void check_sample(input logic signed [SMP_BITS-1:0] got);
            logic signed [SMP_BITS-1:0] want;
            if (expected_samples.size() == 0)
            begin
                $error("sample: no word expected, actual %0d", got);
                err_count++;
            end
            else
            begin
                want = expected_samples.pop_front();
                if (got !== want)
                begin
                    $error("sample mismatch: expected %0d, actual %0d", want, got);
                    err_count++;
                end
            end
        endfunction

        function int pending();
            return expected_samples.size();
        endfunction
    endclass

    logic                         clk       = 1'b0;
    logic                         rst_n     = 1'b0;
    logic                         in_valid  = 1'b0;
    logic                         in_stall;
    logic                         data_bit  = 1'b0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic signed [SMP_BITS-1:0]   sample;
    logic                         psel      = 1'b0;
    logic                         penable   = 1'b0;
    logic                         pwrite    = 1'b0;
    logic [APB_ADDR_BITS-1:0]     paddr     = '0;
    logic [APB_DATA_BITS-1:0]     pwdata    = '0;
    logic [APB_DATA_BITS-1:0]     prdata;
    logic                         pready;

    carrier_scoreboard sb;
    bit                tx_idle     = 1'b1;
    bit                rx_idle     = 1'b1;
    bit                hold_long   = 1'b0;
    int unsigned       cycle_count = 0;

    keyed_carrier_modulator_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_bit  (data_bit),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sample    (sample),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            sb.check_sample(sample);
        end
    end

    initial
    begin
        int n;
        while (rst_n !== 1'b1)
        begin
            @(posedge clk);
        end
        forever
        begin
            n = rx_idle ? $urandom_range(0, 14) : 0;
            if (hold_long)
            begin
                n = HOLD_CYCLES;
                hold_long = 1'b0;
            end
            repeat (n)
            begin
                out_stall <= 1'b1;
                @(posedge clk);
            end
            out_stall <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while (!out_valid);
        end
    end

    task automatic send_word(input bit b);
        int gap;
        gap = tx_idle ? $urandom_range(0, 14) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        data_bit <= b;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        sb.note_word(b);
    endtask

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            send_word(1'($urandom_range(0, 1)));
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic apb_write(input logic [REG_INDEX_BITS-1:0] idx,
                             input logic [APB_DATA_BITS-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_BITS'({idx, 2'b00});
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        sb.write_reg(idx, v);
    endtask

    task automatic configure(input logic [APB_DATA_BITS-1:0] m,
                             input logic [APB_DATA_BITS-1:0] sa,
                             input logic [APB_DATA_BITS-1:0] sbv,
                             input logic [APB_DATA_BITS-1:0] a0,
                             input logic [APB_DATA_BITS-1:0] a1,
                             input bit spare);
        apb_write(REG_MODE, m);
        apb_write(REG_STEP_A, sa);
        apb_write(REG_STEP_B, sbv);
        apb_write(REG_AMP_ZERO, a0);
        apb_write(REG_AMP_ONE, a1);
        if (spare)
        begin
            for (int r = SPARE_REG_FIRST; r < (1 << REG_INDEX_BITS); r++)
            begin
                apb_write(REG_INDEX_BITS'(r), $urandom);
            end
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [APB_DATA_BITS-1:0] pick_step();
        case ($urandom_range(0, 5))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return $urandom_range(0, 1 << 24);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [APB_DATA_BITS-1:0] pick_amp();
        logic [APB_DATA_BITS-1:0] r;
        r = $urandom;
        case ($urandom_range(0, 3))
            0:       r[AMP_BITS-1:0] = '0;
            1:       r[AMP_BITS-1:0] = '1;
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [APB_DATA_BITS-1:0] pick_mode();
        logic [APB_DATA_BITS-1:0] r;
        r = $urandom;
        case ($urandom_range(0, 6))
            0, 1:    r[MODE_BITS-1:0] = MODE_ASK;
            2, 3:    r[MODE_BITS-1:0] = MODE_FSK;
            4, 5:    r[MODE_BITS-1:0] = MODE_PSK;
            default: r[MODE_BITS-1:0] = MODE_NONE;
        endcase
        return r;
    endfunction

    initial
    begin
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: amplitude keying with a silent zero level.
        for (int i = 0; i < 6; i++)
        begin
            send_word(1'(i % 2));
        end
        drain();

        // Bring carrier A back to phase zero, then walk it in quarter turns.
        configure(32'(MODE_PSK), 32'(-sb.acc_a), 32'h0, 32'h7FFF, 32'h7FFF, 1'b0);
        send_word(1'b0);
        drain();
        configure({30'h3FFF_FFFF, MODE_PSK}, 32'h4000_0000, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 32'h0001_0000, 1'b1);
        send_word(1'b0);
        send_word(1'b1);
        send_word(1'b1);
        send_word(1'b0);
        send_word(1'b1);
        send_word(1'b0);
        drain();

        configure(32'(MODE_ASK), 32'hFFFF_FFFF, 32'h0, 32'hFFFF_7FFF, 32'hFFFF_8000, 1'b0);
        for (int i = 0; i < 4; i++)
        begin
            send_word(1'(i % 2));
        end
        drain();

        configure(32'(MODE_FSK), 32'h0, 32'h4000_0000, 32'h0, 32'h7FFF, 1'b0);
        send_word(1'b0);
        send_word(1'b1);
        send_word(1'b1);
        send_word(1'b0);
        send_word(1'b1);
        drain();

        // The unused keying code gives silence while the phases keep moving.
        configure(32'hFFFF_FFFF, pick_step(), pick_step(), pick_amp(), pick_amp(), 1'b1);
        send_random(3);
        drain();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            configure(pick_mode(), pick_step(), pick_step(), pick_amp(), pick_amp(),
                      $urandom_range(0, 3) == 0);
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            if (ph == 2)
            begin
                tx_idle   = 1'b0;
                hold_long = 1'b1;
            end
            send_random(PHASE_WORDS);
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.err_count == 0 && sb.pending() == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/kcm_pkg.sv
rtl/kcm_sine_rom.sv
rtl/keyed_carrier_modulator_unit.sv
rtl/kcm_checker.sv
bench/tb_top.sv
